### design/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// shared widths and constants for the longest consecutive run table
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

    localparam int VALUE_BITS_DEF = 12;
    localparam int LEN_BITS       = 13;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

endpackage

`default_nettype wire

### design/longest_consecutive_run_interval_table.sv
// ----------------------------------------------------------------------------
// longest_consecutive_run_interval_table: longest run of consecutive values
// a new value passes through idle, 3 table reads, merge, 3 writes and update
// a duplicate value skips the writes and goes from merge straight to update
// a last item raises its result from the update state, which waits until the output is free
// after a last item, and after reset, a clear pass over all 2^VALUE_BITS table entries runs
// ----------------------------------------------------------------------------
`default_nettype none

module longest_consecutive_run_interval_table #(
    parameter int VALUE_BITS = lcr_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic                         last,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic        [lcr_pkg::LEN_BITS-1:0] longest_run
);
    import lcr_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int DW    = VB + 1;
    localparam int LW    = VB + 1;
    localparam int CMP_W = (LW > LEN_BITS) ? LW : LEN_BITS;

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_RD_SELF = 10'b0000000100,
        S_RD_LO   = 10'b0000001000,
        S_RD_HI   = 10'b0000010000,
        S_MERGE   = 10'b0000100000,
        S_WR_SELF = 10'b0001000000,
        S_WR_LO   = 10'b0010000000,
        S_WR_HI   = 10'b0100000000,
        S_UPDATE  = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [VB-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [VB-1:0]        idx_reg, idx_next;
    logic                 last_reg, last_next;
    logic                 dup_reg, dup_next;
    logic [VB-1:0]        lo_reg, lo_next;
    logic [VB-1:0]        hi_reg, hi_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [LEN_BITS-1:0]  best_reg, best_next;
    logic [LEN_BITS-1:0]  out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 tbl_we;
    logic [VB-1:0]        tbl_addr;
    logic [DW-1:0]        tbl_wdata;
    logic [DW-1:0]        tbl_rdata;
    logic                 rd_present;
    logic [VB-1:0]        rd_partner;

    logic [LW-1:0]        len_full;
    logic [CMP_W-1:0]     len_ext;
    logic [LEN_BITS-1:0]  len_sat;
    logic [LEN_BITS-1:0]  best_upd;

    lcr_table #(
        .AW (VB),
        .DW (DW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign rd_present = tbl_rdata[DW-1];
    assign rd_partner = tbl_rdata[VB-1:0];

    assign len_full = {1'b0, hi_reg} - {1'b0, lo_reg} + LW'(1);
    assign len_ext  = CMP_W'(len_full);
    assign len_sat  = (len_ext > CMP_W'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_BITS-1:0];
    assign best_upd = (!dup_reg && (len_reg > best_reg)) ? len_reg : best_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        dup_next       = dup_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        len_next       = len_reg;
        best_next      = best_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tbl_we         = 1'b0;
        tbl_addr       = idx_reg;
        tbl_wdata      = {1'b1, hi_reg};

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                tbl_we       = 1'b1;
                tbl_addr     = clr_cnt_reg;
                tbl_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next   = {~value[VB-1], value[VB-2:0]};
                    last_next  = last;
                    state_next = S_RD_SELF;
                end
            end
            S_RD_SELF:
            begin
                tbl_addr   = idx_reg;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                tbl_addr   = idx_reg - 1'b1;
                dup_next   = rd_present;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                tbl_addr   = idx_reg + 1'b1;
                lo_next    = ((idx_reg != '0) && rd_present) ? rd_partner : idx_reg;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                hi_next    = ((idx_reg != '1) && rd_present) ? rd_partner : idx_reg;
                state_next = dup_reg ? S_UPDATE : S_WR_SELF;
            end
            S_WR_SELF:
            begin
                tbl_we     = 1'b1;
                tbl_addr   = idx_reg;
                tbl_wdata  = {1'b1, hi_reg};
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                tbl_we     = 1'b1;
                tbl_addr   = lo_reg;
                tbl_wdata  = {1'b1, hi_reg};
                state_next = S_WR_HI;
            end
            S_WR_HI:
            begin
                tbl_we     = 1'b1;
                tbl_addr   = hi_reg;
                tbl_wdata  = {1'b1, lo_reg};
                len_next   = len_sat;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!last_reg)
                begin
                    best_next  = best_upd;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || result_ready)
                begin
                    out_next       = best_upd;
                    out_valid_next = 1'b1;
                    best_next      = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        last_reg <= last_next;
        dup_reg  <= dup_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        len_reg  <= len_next;
        out_reg  <= out_next;
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign longest_run  = out_reg;

endmodule

`default_nettype wire

### design/lcr_table.sv
// ----------------------------------------------------------------------------
// lcr_table
// single port table holding a present bit and a run partner per value
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_table #(
    parameter int AW = lcr_pkg::VALUE_BITS_DEF,
    parameter int DW = lcr_pkg::VALUE_BITS_DEF + 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);
    import lcr_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/lcr_checker.sv
// ----------------------------------------------------------------------------
// lcr_checker
// port level checks for the longest consecutive run table
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_checker #(
    parameter int VALUE_BITS = lcr_pkg::VALUE_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_ready,
    input wire logic signed [VALUE_BITS-1:0]  value,
    input wire logic                          last,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [lcr_pkg::LEN_BITS-1:0]  longest_run
);
    import lcr_pkg::*;

    // held result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(longest_run))
        else $error("result changed while stalled");

    // any finished set holds at least one value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> longest_run != '0)
        else $error("zero run length");

    // block is busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after accept");

    // a new result starts the clear pass
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !item_ready)
        else $error("ready while clearing");

endmodule

bind longest_consecutive_run_interval_table lcr_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .value        (value),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .longest_run  (longest_run)
);

`default_nettype wire
